### rtl/core/pic_pkg.sv
// Shared types, codes and helper functions for the priority interrupt controller.
// No dependencies; every other file of the block imports this package.
package pic_pkg;

    localparam int LINE_MAX      = 8;
    localparam int LINES_DEFAULT = 8;
    localparam int IDX_W         = 3;
    localparam int VEC_SHIFT     = 3;

    localparam logic [1:0] ACT_SAMPLE = 2'd0;
    localparam logic [1:0] ACT_ACK    = 2'd1;
    localparam logic [1:0] ACT_EOI    = 2'd2;
    localparam logic [1:0] ACT_NONE   = 2'd3;

    localparam logic [2:0] CFG_X86_MODE    = 3'd0;
    localparam logic [2:0] CFG_X86_BASE    = 3'd1;
    localparam logic [2:0] CFG_LOW_PART    = 3'd2;
    localparam logic [2:0] CFG_HIGH_PART   = 3'd3;
    localparam logic [2:0] CFG_AUTO_EOI    = 3'd4;
    localparam logic [2:0] CFG_SINGLE_MODE = 3'd5;
    localparam logic [2:0] CFG_CASCADE     = 3'd6;
    localparam logic [2:0] CFG_LINE_ENABLE = 3'd7;

    typedef struct packed {
        logic       x86_mode;
        logic [4:0] x86_vector_base;
        logic [2:0] vector_low_part;
        logic [7:0] vector_high_part;
        logic       auto_eoi;
        logic       single_mode;
        logic [7:0] cascade_lines;
        logic [7:0] line_enable;
    } cfg_t;

    typedef struct packed {
        logic       int_request;
        logic       vector_valid;
        logic [7:0] vector;
        logic [7:0] cascaded;
    } result_t;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
    } enc_t;

    // Finds the lowest set bit, which is the highest-priority line.
    function automatic enc_t lowest_line(input logic [LINE_MAX-1:0] bits);
        enc_t r;
        r.found = 1'b0;
        r.idx   = '0;
        for (int i = LINE_MAX - 1; i >= 0; i--) begin
            if (bits[i])
            begin
                r.found = 1'b1;
                r.idx   = IDX_W'(i);
            end
        end
        return r;
    endfunction

endpackage

### rtl/core/pic_cfg_regs.sv
// Configuration register file of the priority interrupt controller.
// Depends on pic_pkg for the register index codes and the cfg_t type.
module pic_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [7:0]    cfg_data,
    output pic_pkg::cfg_t cfg
);
    import pic_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_X86_MODE:    cfg_next.x86_mode         = cfg_data[0];
                CFG_X86_BASE:    cfg_next.x86_vector_base  = cfg_data[4:0];
                CFG_LOW_PART:    cfg_next.vector_low_part  = cfg_data[2:0];
                CFG_HIGH_PART:   cfg_next.vector_high_part = cfg_data;
                CFG_AUTO_EOI:    cfg_next.auto_eoi         = cfg_data[0];
                CFG_SINGLE_MODE: cfg_next.single_mode      = cfg_data[0];
                CFG_CASCADE:     cfg_next.cascade_lines    = cfg_data;
                CFG_LINE_ENABLE: cfg_next.line_enable      = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x86_mode         <= 1'b1;
            cfg_reg.x86_vector_base  <= 5'd1;
            cfg_reg.vector_low_part  <= '0;
            cfg_reg.vector_high_part <= '0;
            cfg_reg.auto_eoi         <= 1'b0;
            cfg_reg.single_mode      <= 1'b1;
            cfg_reg.cascade_lines    <= '0;
            cfg_reg.line_enable      <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/core/pic_engine.sv
// Pending, request and in-service registers with the per-word priority logic.
// Depends on pic_pkg for action codes, the encoder function and the struct types.
module pic_engine #(
    parameter int LINES = pic_pkg::LINES_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  logic [1:0]       action,
    input  logic [LINES-1:0] pulses,
    input  pic_pkg::cfg_t    cfg,
    output pic_pkg::result_t res
);
    import pic_pkg::*;

    logic [LINES-1:0] pending_reg, pending_next;
    logic [LINES-1:0] requested_reg, requested_next;
    logic [LINES-1:0] in_service_reg, in_service_next;

    logic [LINES-1:0]    pend_all;
    logic [LINE_MAX-1:0] samp_bits, req_bits, isr_bits;
    enc_t                samp_enc, req_enc, isr_enc;
    logic [LINES-1:0]    samp_hot, req_hot, isr_hot;
    logic [LINES-1:0]    one;
    logic [7:0]          base;
    logic [7:0]          req_hot_ext;
    logic                blocked;

    assign one = LINES'(1);

    always_comb
    begin
        pend_all  = pending_reg | pulses;
        samp_bits = '0;
        req_bits  = '0;
        isr_bits  = '0;
        samp_bits[LINES-1:0] = pend_all & cfg.line_enable[LINES-1:0];
        req_bits[LINES-1:0]  = requested_reg;
        isr_bits[LINES-1:0]  = in_service_reg;
        samp_enc  = lowest_line(samp_bits);
        req_enc   = lowest_line(req_bits);
        isr_enc   = lowest_line(isr_bits);
        samp_hot  = one << samp_enc.idx;
        req_hot   = one << req_enc.idx;
        isr_hot   = one << isr_enc.idx;
        req_hot_ext = '0;
        req_hot_ext[LINES-1:0] = req_hot;
        blocked   = (in_service_reg != '0) && (samp_hot >= in_service_reg);

        if (cfg.x86_mode)
            base = {cfg.x86_vector_base, 3'b000};
        else
            base = {5'b00000, cfg.vector_low_part}
                 + {cfg.vector_high_part[7-VEC_SHIFT:0], 3'b000};

        pending_next    = pend_all;
        requested_next  = requested_reg;
        in_service_next = in_service_reg;
        res             = '0;

        unique case (action)
            ACT_SAMPLE:
            begin
                if (samp_enc.found)
                begin
                    pending_next = pend_all & ~samp_hot;
                    if (!blocked)
                    begin
                        requested_next  = requested_reg | samp_hot;
                        res.int_request = 1'b1;
                    end
                end
            end
            ACT_ACK:
            begin
                if (req_enc.found)
                begin
                    requested_next = requested_reg & ~req_hot;
                    if (!cfg.auto_eoi)
                        in_service_next = in_service_reg | req_hot;
                    if (!cfg.single_mode && ((cfg.cascade_lines & req_hot_ext) != '0))
                    begin
                        res.cascaded = req_hot_ext;
                    end
                    else
                    begin
                        res.vector_valid = 1'b1;
                        res.vector       = base + {5'b00000, req_enc.idx};
                    end
                end
            end
            ACT_EOI:
            begin
                if (isr_enc.found)
                    in_service_next = in_service_reg & ~isr_hot;
            end
            ACT_NONE:
            begin
                pending_next = pend_all;
            end
            default:
            begin
                pending_next = pend_all;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg    <= '0;
            requested_reg  <= '0;
            in_service_reg <= '0;
        end
        else if (go)
        begin
            pending_reg    <= pending_next;
            requested_reg  <= requested_next;
            in_service_reg <= in_service_next;
        end
    end

`ifndef SYNTH
    a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !go |=> $stable(pending_reg) && $stable(requested_reg) && $stable(in_service_reg))
        else $error("interrupt state changed without a word");

    a_vector_or_cascade: assert property (@(posedge clk) disable iff (!rst_n)
        !(res.vector_valid && (res.cascaded != '0)))
        else $error("vector and cascade flagged together");

    a_auto_eoi_keeps_isr: assert property (@(posedge clk) disable iff (!rst_n)
        (go && (action == ACT_ACK) && cfg.auto_eoi) |=> $stable(in_service_reg))
        else $error("auto end of interrupt acknowledge set an in-service bit");

    a_eoi_only_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (go && (action == ACT_EOI)) |=> ((in_service_reg & ~$past(in_service_reg)) == '0))
        else $error("end of interrupt set an in-service bit");
`endif

endmodule

### rtl/core/priority_interrupt_controller.sv
// Top level of the fixed-priority interrupt controller: stream ports, input and
// result registers. Depends on pic_pkg, pic_cfg_regs and pic_engine.
//
// One word is taken every clock cycle when the result side keeps up. A word goes
// through an input register and then a result register, from which its result is
// presented. While a finished result waits, the input register takes one more word
// and then s_tready stays low until the result side takes a word. The pending,
// request and in-service registers are updated as a word moves on to the result
// register, through three eight-line priority encoders and the vector adder. Line 0
// has the highest priority. The user must write configuration through the plain
// write port only while idle; the block itself does not enforce this.
module priority_interrupt_controller #(
    parameter int LINES = pic_pkg::LINES_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] request_pulses
    input  logic [1:0]  s_tuser,   // [1:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] vector, [15:8] cascaded
    output logic [1:0]  m_tuser,   // [0] int_request, [1] vector_valid
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import pic_pkg::*;

    cfg_t             cfg;
    result_t          res;
    result_t          out_res_reg;
    logic             in_valid_reg, in_valid_next;
    logic             out_valid_reg, out_valid_next;
    logic [1:0]       in_action_reg;
    logic [LINES-1:0] in_pulses_reg;
    logic             advance;
    logic             take;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign take     = s_tvalid && s_tready;

    pic_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pic_engine #(
        .LINES (LINES)
    ) u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (advance),
        .action (in_action_reg),
        .pulses (in_pulses_reg),
        .cfg    (cfg),
        .res    (res)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_action_reg <= s_tuser;
            in_pulses_reg <= s_tdata[LINES-1:0];
        end
        if (advance)
            out_res_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_res_reg.cascaded, out_res_reg.vector};
    assign m_tuser  = {out_res_reg.vector_valid, out_res_reg.int_request};

endmodule
